### hdl/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg: shared types and constants of the dominant color classifier
// Holds the histogram widths, the sequencer states, the control bundle
// sent to the channels and the color classification function.
// ----------------------------------------------------------------------------
package dcc_pkg;

   localparam int BIN_COUNT     = 256;
   localparam int BIN_BITS      = $clog2(BIN_COUNT);
   localparam int COUNT_BITS    = 19;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 32;
   localparam int CLASS_BITS    = 2;

   typedef logic [BIN_BITS-1:0]   bin_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [CLASS_BITS-1:0] class_type;

   localparam count_type COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam bin_type   BIN_LAST  = bin_type'(BIN_COUNT - 1);

   // Color class codes.
   localparam class_type CLASS_NONE   = 2'd0;
   localparam class_type CLASS_YELLOW = 2'd1;
   localparam class_type CLASS_RED    = 2'd2;
   localparam class_type CLASS_GREEN  = 2'd3;

   // Classification thresholds on the channel modes.
   localparam bin_type YELLOW_MIN = 8'd150;
   localparam bin_type RED_R_MIN  = 8'd130;
   localparam bin_type LIMIT_MAX  = 8'd140;
   localparam bin_type GREEN_MIN  = 8'd100;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_DRAIN,
      ST_SCAN,
      ST_FINISH,
      ST_EMIT
   } state_type;

   // Control bundle from the sequencer to each histogram channel.
   typedef struct packed {
      logic    update;      // a pixel beat was accepted this cycle
      logic    scan_read;   // read bin at addr for the mode search
      logic    clear_write; // write zero to bin at addr
      logic    scan_start;  // restart the best-bin tracker
      bin_type addr;        // sweep address
   } ctl_type;

   // Yellow first, then red, then green, else none.
   function automatic class_type classify(bin_type red, bin_type green, bin_type blue);
      class_type result;
      result = CLASS_NONE;
      if (red >= YELLOW_MIN && green >= YELLOW_MIN && blue <= LIMIT_MAX) begin
         result = CLASS_YELLOW;
      end else if (red >= RED_R_MIN && green <= LIMIT_MAX && blue <= LIMIT_MAX) begin
         result = CLASS_RED;
      end else if (red <= LIMIT_MAX && green >= GREEN_MIN && blue <= LIMIT_MAX) begin
         result = CLASS_GREEN;
      end
      return result;
   endfunction

endpackage

### hdl/dcc_ram.sv
// ----------------------------------------------------------------------------
// dcc_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and
// returns the old contents when the same entry is written in that cycle.
// ----------------------------------------------------------------------------
module dcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/dcc_hist_channel.sv
// ----------------------------------------------------------------------------
// dcc_hist_channel: one color channel's histogram and mode search
// Read-modify-write of the bin of each pixel with forwarding of the
// previous write, and a best-bin tracker fed by the clearing sweep.
// ----------------------------------------------------------------------------
module dcc_hist_channel (
   input  logic             clock,
   input  logic             reset,
   input  dcc_pkg::ctl_type ctl,
   input  dcc_pkg::bin_type pixel,
   output dcc_pkg::bin_type mode
);

   dcc_pkg::bin_type   rd_addr;
   dcc_pkg::count_type rd_data;
   logic               wr_en;
   dcc_pkg::bin_type   wr_addr;
   dcc_pkg::count_type wr_data;

   logic               upd_valid_ff, upd_valid_in;
   dcc_pkg::bin_type   upd_addr_ff, upd_addr_in;
   logic               scan_valid_ff, scan_valid_in;
   dcc_pkg::bin_type   scan_idx_ff, scan_idx_in;
   logic               fwd_valid_ff, fwd_valid_in;
   dcc_pkg::bin_type   fwd_addr_ff, fwd_addr_in;
   dcc_pkg::count_type fwd_data_ff, fwd_data_in;
   dcc_pkg::count_type best_cnt_ff, best_cnt_in;
   dcc_pkg::bin_type   best_idx_ff, best_idx_in;

   dcc_pkg::count_type old_count;
   dcc_pkg::count_type new_count;

   dcc_ram #(
      .WIDTH (dcc_pkg::COUNT_BITS),
      .DEPTH (dcc_pkg::BIN_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = ctl.scan_read ? ctl.addr : pixel;

   // The bin written in the previous cycle is not yet visible in the read
   // data, so a back-to-back hit on the same bin takes the forwarded count.
   always_comb begin
      old_count = rd_data;
      if (fwd_valid_ff && fwd_addr_ff == upd_addr_ff) begin
         old_count = fwd_data_ff;
      end
      new_count = (old_count == dcc_pkg::COUNT_MAX) ? old_count
                                                     : old_count + 1'b1;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ctl.addr;
      wr_data = '0;
      if (upd_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = upd_addr_ff;
         wr_data = new_count;
      end else if (ctl.clear_write) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      upd_valid_in  = ctl.update;
      upd_addr_in   = pixel;
      scan_valid_in = ctl.scan_read;
      scan_idx_in   = ctl.addr;
      fwd_valid_in  = upd_valid_ff;
      fwd_addr_in   = upd_addr_ff;
      fwd_data_in   = new_count;
      best_cnt_in   = best_cnt_ff;
      best_idx_in   = best_idx_ff;
      if (ctl.scan_start) begin
         best_cnt_in = '0;
         best_idx_in = '0;
      end else if (scan_valid_ff && rd_data > best_cnt_ff) begin
         best_cnt_in = rd_data;
         best_idx_in = scan_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_valid_ff  <= 1'b0;
         scan_valid_ff <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         best_cnt_ff   <= '0;
         best_idx_ff   <= '0;
      end else begin
         upd_valid_ff  <= upd_valid_in;
         scan_valid_ff <= scan_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         best_cnt_ff   <= best_cnt_in;
         best_idx_ff   <= best_idx_in;
      end
      upd_addr_ff <= upd_addr_in;
      scan_idx_ff <= scan_idx_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

   assign mode = best_idx_ff;

endmodule

### hdl/dominant_color_classifier.sv
// ----------------------------------------------------------------------------
// dominant_color_classifier: region color classification by histogram mode
// Counts the blue, green and red values of a region's pixels in three
// 256-bin histograms, finds each channel's mode at the region's end and
// classifies the region as yellow, red, green or none.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-------------------------------
//  req     | in        | req_tvalid/req_tready | tdata blue, green, red; tlast
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata modes red, green, blue,
//          |           |                       | color class
//
// A pixel beat is taken every cycle while a region is collected, with the
// previous histogram write forwarded on a repeated bin. After the beat marked
// last, intake stops for the final update, a sweep of all bins (mode search
// and clear), the last compare and the load of the output register once it is
// free; the register holds until the consumer takes it. After reset, a
// clearing sweep zeroes all bins of the RAMs before the first beat is accepted.
//
module dominant_color_classifier (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] pixel_blue, [15:8] pixel_green, [23:16] pixel_red
   input  logic [dcc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // last_pixel
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] mode_red, [15:8] mode_green, [23:16] mode_blue,
   // [25:24] color_class, [31:26] zero
   output logic [dcc_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   dcc_pkg::state_type state_ff, state_in;
   dcc_pkg::bin_type   addr_ff, addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [dcc_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   dcc_pkg::ctl_type   ctl;
   logic               req_accept;
   logic               rsp_load;
   logic               rsp_free;
   dcc_pkg::bin_type   mode_red;
   dcc_pkg::bin_type   mode_green;
   dcc_pkg::bin_type   mode_blue;
   dcc_pkg::class_type color_class;

   // One histogram per color channel, each with its own RAM.
   dcc_hist_channel u_blue (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .pixel (req_tdata[7:0]),
      .mode  (mode_blue)
   );

   dcc_hist_channel u_green (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .pixel (req_tdata[15:8]),
      .mode  (mode_green)
   );

   dcc_hist_channel u_red (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .pixel (req_tdata[23:16]),
      .mode  (mode_red)
   );

   assign req_accept  = req_tvalid && req_tready;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign color_class = dcc_pkg::classify(mode_red, mode_green, mode_blue);

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dcc_pkg::ST_CLEAR: begin
            if (addr_ff == dcc_pkg::BIN_LAST) begin
               state_in = dcc_pkg::ST_RUN;
            end
         end
         dcc_pkg::ST_RUN: begin
            if (req_accept && req_tlast) begin
               state_in = dcc_pkg::ST_DRAIN;
            end
         end
         dcc_pkg::ST_DRAIN: begin
            state_in = dcc_pkg::ST_SCAN;
         end
         dcc_pkg::ST_SCAN: begin
            if (addr_ff == dcc_pkg::BIN_LAST) begin
               state_in = dcc_pkg::ST_FINISH;
            end
         end
         dcc_pkg::ST_FINISH: begin
            state_in = dcc_pkg::ST_EMIT;
         end
         dcc_pkg::ST_EMIT: begin
            if (rsp_free) begin
               state_in = dcc_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = dcc_pkg::ST_CLEAR;
         end
      endcase
   end

   // Output decode of the sequencer: channel controls, ready and result load.
   always_comb begin
      ctl             = '0;
      ctl.addr        = addr_ff;
      req_tready      = 1'b0;
      rsp_load        = 1'b0;
      case (state_ff)
         dcc_pkg::ST_CLEAR: begin
            ctl.clear_write = 1'b1;
         end
         dcc_pkg::ST_RUN: begin
            req_tready = 1'b1;
            ctl.update = req_tvalid;
         end
         dcc_pkg::ST_DRAIN: begin
            ctl.scan_start = 1'b1;
         end
         dcc_pkg::ST_SCAN: begin
            ctl.scan_read   = 1'b1;
            ctl.clear_write = 1'b1;
         end
         dcc_pkg::ST_FINISH: begin
            ctl.scan_start = 1'b0;
         end
         dcc_pkg::ST_EMIT: begin
            rsp_load = rsp_free;
         end
         default: begin
            ctl.clear_write = 1'b0;
         end
      endcase
   end

   // The sweep address runs only while clearing or scanning and wraps to
   // zero at the end of each sweep.
   always_comb begin
      addr_in = addr_ff;
      if (state_ff == dcc_pkg::ST_CLEAR || state_ff == dcc_pkg::ST_SCAN) begin
         addr_in = addr_ff + 1'b1;
      end
   end

   // The output register holds a finished result until the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = dcc_pkg::RSP_DATA_BITS'({color_class, mode_blue,
                                                 mode_green, mode_red});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dcc_pkg::ST_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // The beat marked last closes the region and stops intake for the drain.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> state_ff == dcc_pkg::ST_DRAIN && !req_tready)
      else $error("last beat did not close the region");

   // A full sweep ends exactly after the last bin.
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == dcc_pkg::ST_SCAN && addr_ff == dcc_pkg::BIN_LAST
      |=> state_ff == dcc_pkg::ST_FINISH && addr_ff == '0)
      else $error("bin sweep did not end after the last bin");

   // A result is loaded only into a free output register.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff || rsp_tready)
      else $error("result overwrote a pending result");

   // A result is only emitted after a completed sweep.
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == dcc_pkg::ST_EMIT
      |-> $past(state_ff) == dcc_pkg::ST_FINISH || $past(state_ff) == dcc_pkg::ST_EMIT)
      else $error("result emitted without a completed sweep");
`endif

endmodule
